// ===== rtl/adsc_pkg.sv =====
// ----------------------------------------------------------------------------
// adsc_pkg
// shared types and constants of the service data classifier
// ----------------------------------------------------------------------------
`default_nettype none

package adsc_pkg;

  // ad structure type for 16-bit service data
  localparam logic [7:0]  AdServiceData16 = 8'h16;
  localparam logic [15:0] UuidReset       = 16'hFEE4;

  // packet type codes carried after the uuid
  localparam logic [15:0] PktFwid    = 16'hFFFE;
  localparam logic [15:0] PktState   = 16'hFFFD;
  localparam logic [15:0] PktData    = 16'hFFFC;
  localparam logic [15:0] PktDataReq = 16'hFFFB;
  localparam logic [15:0] PktDataRsp = 16'hFFFA;

  // minimum structure lengths for emitting a result and for the optional fields
  localparam logic [7:0] MinLenEmit     = 8'd5;
  localparam logic [7:0] MinLenSegment  = 8'd7;
  localparam logic [7:0] MinLenTransfer = 8'd11;

  // configuration register indexes
  localparam logic CfgOwnTransferId = 1'b0;
  localparam logic CfgServiceUuid   = 1'b1;

  typedef enum logic [2:0] {
    KIND_DATA_REQ = 3'd0,
    KIND_STATE    = 3'd1,
    KIND_DATA     = 3'd2,
    KIND_BEACON   = 3'd3,
    KIND_OTHER    = 3'd4
  } kind_e;

  typedef struct packed {
    logic [31:0] beacon_count;
    logic [31:0] offer_count;
    logic [31:0] request_count;
    logic        is_ours;
    logic [31:0] request_transfer;
    logic [15:0] segment;
    kind_e       packet_kind;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/adsc_parser.sv =====
// ----------------------------------------------------------------------------
// adsc_parser
// ad structure walker, field capture, classification and counters
// ----------------------------------------------------------------------------
`default_nettype none

module adsc_parser
  import adsc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_i,
  input  wire logic [7:0]  byte_i,
  input  wire logic        last_i,
  input  wire logic [31:0] own_id_i,
  input  wire logic [15:0] uuid_i,
  output logic             res_valid_o,
  output result_t          res_o
);

  logic [7:0]  len_q, len_d;
  logic [7:0]  pos_q, pos_d;
  logic [7:0]  type_q, type_d;
  logic        low_q, low_d;
  logic        match_q, match_d;
  logic        stop_q, stop_d;
  logic [15:0] ptype_q, ptype_d;
  logic [15:0] seg_q, seg_d;
  logic [31:0] tid_q, tid_d;
  logic [31:0] req_q, req_d;
  logic [31:0] off_q, off_d;
  logic [31:0] bcn_q, bcn_d;

  logic        in_struct;
  logic [8:0]  pos_inc;
  logic        done;
  logic [7:0]  type_n;
  logic        low_n, match_n;
  logic [15:0] ptype_n, seg_n;
  logic [31:0] tid_n;
  logic        emit;
  kind_e       kind;
  logic        is_req;
  logic [31:0] tid_out;

  assign in_struct = !stop_q && (len_q != 8'd0);
  assign pos_inc   = {1'b0, pos_q} + 9'd1;
  assign done      = in_struct && (pos_inc >= {1'b0, len_q});

  // capture of the current byte at its structure position
  always_comb begin
    type_n  = type_q;
    low_n   = low_q;
    match_n = match_q;
    ptype_n = ptype_q;
    seg_n   = seg_q;
    tid_n   = tid_q;
    if (in_struct) begin
      unique case (pos_q)
        8'd0:    type_n = byte_i;
        8'd1:    low_n = (byte_i == uuid_i[7:0]);
        8'd2:    match_n = low_q && (byte_i == uuid_i[15:8]);
        8'd3:    ptype_n[7:0] = byte_i;
        8'd4:    ptype_n[15:8] = byte_i;
        8'd5:    seg_n[7:0] = byte_i;
        8'd6:    seg_n[15:8] = byte_i;
        8'd7:    tid_n[7:0] = byte_i;
        8'd8:    tid_n[15:8] = byte_i;
        8'd9:    tid_n[23:16] = byte_i;
        8'd10:   tid_n[31:24] = byte_i;
        default: ;
      endcase
    end
  end

  assign emit = done && (type_n == AdServiceData16) && match_n && (len_q >= MinLenEmit);

  always_comb begin
    priority if (ptype_n == PktDataReq) begin
      kind = KIND_DATA_REQ;
    end else if (ptype_n == PktState) begin
      kind = KIND_STATE;
    end else if (ptype_n == PktData || ptype_n == PktDataRsp) begin
      kind = KIND_DATA;
    end else if (ptype_n == PktFwid) begin
      kind = KIND_BEACON;
    end else begin
      kind = KIND_OTHER;
    end
  end

  assign is_req  = (kind == KIND_DATA_REQ);
  assign tid_out = (is_req && len_q >= MinLenTransfer) ? tid_n : 32'd0;

  // counters after this result's increment
  assign req_d = (emit && kind == KIND_DATA_REQ) ? req_q + 32'd1 : req_q;
  assign off_d = (emit && kind == KIND_STATE)    ? off_q + 32'd1 : off_q;
  assign bcn_d = (emit && kind == KIND_BEACON)   ? bcn_q + 32'd1 : bcn_q;

  assign res_valid_o            = emit;
  assign res_o.packet_kind      = kind;
  assign res_o.segment          = (is_req && len_q >= MinLenSegment) ? seg_n : 16'd0;
  assign res_o.request_transfer = tid_out;
  assign res_o.is_ours          = is_req && (tid_out == own_id_i);
  assign res_o.request_count    = req_d;
  assign res_o.offer_count      = off_d;
  assign res_o.beacon_count     = bcn_d;

  // parse state update
  always_comb begin
    len_d   = len_q;
    pos_d   = pos_q;
    type_d  = type_n;
    low_d   = low_n;
    match_d = match_n;
    stop_d  = stop_q;
    ptype_d = ptype_n;
    seg_d   = seg_n;
    tid_d   = tid_n;
    if (!stop_q && len_q == 8'd0) begin
      if (byte_i == 8'd0) begin
        stop_d = 1'b1;
      end else begin
        len_d = byte_i;
        pos_d = 8'd0;
      end
    end else if (in_struct) begin
      pos_d = pos_inc[7:0];
      if (done) begin
        len_d   = 8'd0;
        pos_d   = 8'd0;
        type_d  = 8'd0;
        low_d   = 1'b0;
        match_d = 1'b0;
        ptype_d = 16'd0;
        seg_d   = 16'd0;
        tid_d   = 32'd0;
      end
    end
    if (last_i) begin
      len_d   = 8'd0;
      pos_d   = 8'd0;
      type_d  = 8'd0;
      low_d   = 1'b0;
      match_d = 1'b0;
      stop_d  = 1'b0;
      ptype_d = 16'd0;
      seg_d   = 16'd0;
      tid_d   = 32'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      pos_q   <= '0;
      type_q  <= '0;
      low_q   <= 1'b0;
      match_q <= 1'b0;
      stop_q  <= 1'b0;
      ptype_q <= '0;
      seg_q   <= '0;
      tid_q   <= '0;
      req_q   <= '0;
      off_q   <= '0;
      bcn_q   <= '0;
    end else if (step_i) begin
      len_q   <= len_d;
      pos_q   <= pos_d;
      type_q  <= type_d;
      low_q   <= low_d;
      match_q <= match_d;
      stop_q  <= stop_d;
      ptype_q <= ptype_d;
      seg_q   <= seg_d;
      tid_q   <= tid_d;
      req_q   <= req_d;
      off_q   <= off_d;
      bcn_q   <= bcn_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/adv_service_data_dfu_classifier.sv =====
// ----------------------------------------------------------------------------
// adv_service_data_dfu_classifier
// classifies dfu service data structures in advertising reports
// ----------------------------------------------------------------------------
//
// channel   direction  handshake                payload
// s_axis    in         s_axis_tvalid/tready     tdata[7:0] report byte, tlast last byte
// m_axis    out        m_axis_tvalid/tready     tuser packet kind, tdata result fields
// cfg       in         cfg_we_i (no stall)      cfg_idx_i, cfg_data_i
//
// one byte per cycle sustained while m_axis takes results; a result passes the input then the output register
// the parser state update is a single pass between the input and result registers
// a byte that completes no service data structure produces no item
// reset clears the parse state, the counters and the valid flags of both registers at once
// a stall on m_axis backs up into s_axis only once both registers are full
// ----------------------------------------------------------------------------
`default_nettype none

module adv_service_data_dfu_classifier
  import adsc_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // slave side: report bytes
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,  // [7:0] data_byte
  input  wire logic         s_axis_tlast,  // last_byte
  // master side: classification results
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [15:0] segment, [47:16] request_transfer, [48] is_ours,
  // [80:49] request_count, [112:81] offer_count, [144:113] beacon_count, rest zero
  output logic [151:0]      m_axis_tdata,
  output logic [2:0]        m_axis_tuser,  // [2:0] packet_kind
  // configuration write port
  input  wire logic         cfg_we_i,
  input  wire logic         cfg_idx_i,
  input  wire logic [31:0]  cfg_data_i
);

  // configuration registers
  logic [31:0] own_id_q;
  logic [15:0] uuid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_id_q <= '0;
      uuid_q   <= UuidReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgOwnTransferId: own_id_q <= cfg_data_i;
        CfgServiceUuid:   uuid_q   <= cfg_data_i[15:0];
        default:          ;
      endcase
    end
  end

  // input register
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       advance;
  logic       in_fire;

  // output register
  logic    out_valid_q, out_valid_d;
  result_t out_q;

  logic    res_valid;
  result_t res;

  // the input item moves into the parser whenever the result slot can take it
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign in_valid_d    = in_fire || (in_valid_q && !advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  adsc_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .byte_i      (in_byte_q),
    .last_i      (in_last_q),
    .own_id_i    (own_id_q),
    .uuid_i      (uuid_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // result slot fills on a classified byte and drains on a downstream take
  assign out_valid_d = (advance && res_valid) || (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.packet_kind;
  assign m_axis_tdata  = {7'd0, out_q.beacon_count, out_q.offer_count, out_q.request_count,
                          out_q.is_ours, out_q.request_transfer, out_q.segment};

`ifndef NO_ASSERTIONS
  // a match flag only comes with a data request
  a_ours_is_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.is_ours) |-> (out_q.packet_kind == KIND_DATA_REQ))
    else $error("is_ours set on a non-request result");

  // request fields stay zero for other kinds
  a_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.packet_kind != KIND_DATA_REQ)
      |-> (out_q.segment == 16'd0 && out_q.request_transfer == 32'd0))
    else $error("request fields set on a non-request result");

  // backpressure only when both registers hold an item and downstream stalls
  a_ready_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && out_valid_q && !m_axis_tready))
    else $error("input stalled without cause");

  // a taken result makes room for the pending byte in the same cycle
  a_drain_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && m_axis_tready) |-> advance)
    else $error("pending byte not moved on a free result slot");
`endif

endmodule

`default_nettype wire
